// ----- hdl/tccw_pkg.sv -----
package tccw_pkg;

   localparam int COLUMNS_DEFAULT = 128;
   localparam int ROWS_DEFAULT    = 64;

   localparam logic [7:0]  NEWLINE_CODE = 8'd10;
   localparam logic [7:0]  SPACE_CODE   = 8'd32;
   localparam logic [15:0] COLOR_RESET  = 16'h07FF;

   typedef enum logic [1:0] {
      ACTION_PUT       = 2'd0,
      ACTION_BACKSPACE = 2'd1,
      ACTION_CLEAR     = 2'd2,
      ACTION_UNUSED    = 2'd3
   } action_type;

   typedef enum logic {
      KIND_DRAW  = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   typedef struct packed {
      action_type action;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  cell_column;
      logic [7:0]  cell_row;
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
      logic [7:0]  glyph;
      logic [15:0] colour;
      logic        last;
   } rsp_type;

endpackage

// ----- hdl/text_console_char_writer.sv -----
// Text console character writer.
// Requests arrive on req_valid/req_ready with an action (put, backspace,
// clear) and a character byte. Draw and clear notices leave on
// rsp_valid/rsp_ready, up to two per request, the final one marked last.
// csr_write_enable/csr_write_data set the colour copied into every notice;
// write it only while the block is idle.
// The character grid lives in one synchronous RAM addressed {row, column}.
// A put or backspace reads the cell when accepted and, in S_CHECK, writes
// it back if it changed; the next request is accepted only after S_CHECK,
// so reads never meet a pending write. A draw notice is registered out of
// S_CHECK and a clear notice out of S_CLEAR_OUT, once the notice register
// is free; an overflow clear waits in S_CLEAR_OUT until any draw notice is taken.
// A clear, or a put that runs past the bottom row, emits a clear notice and
// then sweeps all 2^(clog2(ROWS)+clog2(COLUMNS)) RAM entries (8192 at
// 128 x 64), one entry a cycle, while req_ready stays low.
// Reset starts the same sweep, so the first request is taken after it.
// A stalled receiver holds the notice register; the block waits with its
// request in hand until the notice is taken, and accepts nothing new.
module text_console_char_writer #(
   parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tccw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tccw_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [15:0]       csr_write_data
);
   import tccw_pkg::*;

   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int AW    = CW + RW;
   localparam int DEPTH = 1 << AW;

   localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

   typedef enum logic [1:0] {
      S_WIPE,
      S_IDLE,
      S_CHECK,
      S_CLEAR_OUT
   } state_type;

   logic [7:0] mem [DEPTH];

   state_type     state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] wipe_addr_ff, wipe_addr_in;
   logic [7:0]    value_ff, value_in;
   logic          put_ff, put_in;
   logic          newline_ff, newline_in;
   logic [15:0]   color_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [7:0]    rdata_ff;

   logic          accept;
   logic          slot_free;
   logic          rd_en;
   logic [CW-1:0] rd_col;
   logic [RW-1:0] rd_row;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          changed;
   logic          wrap;
   logic          overflow;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign changed  = (rdata_ff != value_ff);
   assign wrap     = newline_ff || (col_ff == COL_LAST);
   assign overflow = put_ff && wrap && (row_ff == ROW_LAST);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      wipe_addr_in = wipe_addr_ff;
      value_in     = value_ff;
      put_in       = put_ff;
      newline_in   = newline_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_col       = col_ff;
      rd_row       = row_ff;
      wr_en        = 1'b0;
      wr_addr      = {row_ff, col_ff};
      wr_data      = SPACE_CODE;

      unique case (state_ff)
         S_WIPE: begin
            wr_en        = 1'b1;
            wr_addr      = wipe_addr_ff;
            wipe_addr_in = wipe_addr_ff + 1'b1;
            if (wipe_addr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.action)
                  ACTION_PUT: begin
                     put_in     = 1'b1;
                     newline_in = (req_data.char_code == NEWLINE_CODE);
                     value_in   = newline_in ? SPACE_CODE : req_data.char_code;
                     rd_en      = 1'b1;
                     state_in   = S_CHECK;
                  end
                  ACTION_BACKSPACE: begin
                     if (row_ff != '0 || col_ff != '0) begin
                        put_in     = 1'b0;
                        newline_in = 1'b0;
                        value_in   = SPACE_CODE;
                        if (col_ff == '0) begin
                           rd_col = COL_LAST;
                           rd_row = row_ff - 1'b1;
                        end else begin
                           rd_col = col_ff - 1'b1;
                        end
                        col_in   = rd_col;
                        row_in   = rd_row;
                        rd_en    = 1'b1;
                        state_in = S_CHECK;
                     end
                  end
                  ACTION_CLEAR: begin
                     state_in = S_CLEAR_OUT;
                  end
                  ACTION_UNUSED: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (!changed || slot_free) begin
               if (changed) begin
                  wr_en              = 1'b1;
                  wr_data            = value_ff;
                  rsp_valid_in       = 1'b1;
                  rsp_in.kind        = KIND_DRAW;
                  rsp_in.cell_column = 8'(col_ff);
                  rsp_in.cell_row    = 8'(row_ff);
                  rsp_in.pixel_x     = {8'(col_ff), 3'b000};
                  rsp_in.pixel_y     = {8'(row_ff), 3'b000};
                  rsp_in.glyph       = value_ff;
                  rsp_in.colour      = color_ff;
                  rsp_in.last        = !overflow;
               end
               if (put_ff) begin
                  if (wrap) begin
                     col_in = '0;
                     row_in = overflow ? '0 : row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
               state_in = overflow ? S_CLEAR_OUT : S_IDLE;
            end
         end
         S_CLEAR_OUT: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.kind        = KIND_CLEAR;
               rsp_in.cell_column = '0;
               rsp_in.cell_row    = '0;
               rsp_in.pixel_x     = '0;
               rsp_in.pixel_y     = '0;
               rsp_in.glyph       = SPACE_CODE;
               rsp_in.colour      = color_ff;
               rsp_in.last        = 1'b1;
               col_in             = '0;
               row_in             = '0;
               wipe_addr_in       = '0;
               state_in           = S_WIPE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[{rd_row, rd_col}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         col_ff       <= '0;
         row_ff       <= '0;
         wipe_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= COLOR_RESET;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         wipe_addr_ff <= wipe_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            color_ff <= csr_write_data;
         end
      end
      value_ff   <= value_in;
      put_ff     <= put_in;
      newline_ff <= newline_in;
      rsp_ff     <= rsp_in;
   end

   a_caret_in_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= ROW_LAST) && (col_ff <= COL_LAST))
      else $error("caret outside the grid");

   a_clear_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_CLEAR) |-> rsp_ff.last)
      else $error("clear notice not marked last");

   a_clear_starts_wipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR_OUT && slot_free) |=>
         (state_ff == S_WIPE && wipe_addr_ff == '0 && row_ff == '0 && col_ff == '0))
      else $error("clear did not start the sweep from the origin");

   a_overflow_chains_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && overflow && (!changed || slot_free)) |=>
         (state_ff == S_CLEAR_OUT))
      else $error("bottom row overflow without clear");

endmodule

// ----- tb/tb_text_console_char_writer.sv -----
module tb_text_console_char_writer;
   timeunit 1ns;
   timeprecision 1ps;

   import tccw_pkg::*;

   localparam int COLUMNS        = COLUMNS_DEFAULT;
   localparam int ROWS           = ROWS_DEFAULT;
   localparam int CLOCK_PERIOD   = 20;
   localparam int SWEEP_CYCLES   = 1 << ($clog2(ROWS) + $clog2(COLUMNS));
   localparam int SETTLE_CYCLES  = SWEEP_CYCLES + 32;
   localparam int RANDOM_ITEMS   = 2000;
   localparam longint TIMEOUT_CYCLES = 100_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   // shadow of the screen, caret and pen colour
   logic [7:0]  screen_cells [COLUMNS * ROWS];
   int          caret_row;
   int          caret_column;
   logic [15:0] pen_colour;
   rsp_type     pending_notices [$];
   rsp_type     expected_notice;

   int mismatch_count;
   int sent_count;
   int sink_hold_cycles;
   int sink_wait;
   bit quiet_sender;
   bit quiet_sink;

   text_console_char_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic void wipe_screen();
      foreach (screen_cells[i]) screen_cells[i] = SPACE_CODE;
      caret_row = 0;
      caret_column = 0;
   endfunction

   function automatic void push_notice(kind_type kind, int column, int row,
                                       logic [7:0] glyph);
      rsp_type notice;
      notice.kind        = kind;
      notice.cell_column = 8'(column);
      notice.cell_row    = 8'(row);
      notice.pixel_x     = 11'(column * 8);
      notice.pixel_y     = 11'(row * 8);
      notice.glyph       = glyph;
      notice.colour      = pen_colour;
      notice.last        = 1'b0;
      pending_notices.push_back(notice);
   endfunction

   // true when the cell under the caret changes
   function automatic bit store_cell(logic [7:0] value);
      int idx;
      idx = caret_row * COLUMNS + caret_column;
      if (screen_cells[idx] == value) return 1'b0;
      screen_cells[idx] = value;
      return 1'b1;
   endfunction

   function automatic void predict_notices(req_type item);
      int         count_before;
      logic [7:0] value;
      rsp_type    final_notice;
      count_before = pending_notices.size();
      case (item.action)
         ACTION_PUT: begin
            value = (item.char_code == NEWLINE_CODE) ? SPACE_CODE : item.char_code;
            if (store_cell(value)) push_notice(KIND_DRAW, caret_column, caret_row, value);
            if (item.char_code == NEWLINE_CODE || caret_column >= COLUMNS - 1) begin
               caret_row++;
               caret_column = 0;
            end else begin
               caret_column++;
            end
            if (caret_row >= ROWS) begin
               wipe_screen();
               push_notice(KIND_CLEAR, 0, 0, SPACE_CODE);
            end
         end
         ACTION_BACKSPACE: begin
            if (caret_row != 0 || caret_column != 0) begin
               if (caret_column == 0) begin
                  caret_row--;
                  caret_column = COLUMNS - 1;
               end else begin
                  caret_column--;
               end
               if (store_cell(SPACE_CODE))
                  push_notice(KIND_DRAW, caret_column, caret_row, SPACE_CODE);
            end
         end
         ACTION_CLEAR: begin
            wipe_screen();
            push_notice(KIND_CLEAR, 0, 0, SPACE_CODE);
         end
         default: ;
      endcase
      if (pending_notices.size() > count_before) begin
         final_notice = pending_notices.pop_back();
         final_notice.last = 1'b1;
         pending_notices.push_back(final_notice);
      end
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic send_request(action_type op, logic [7:0] code);
      int      gap;
      req_type item;
      gap = quiet_sender ? 0 : $urandom_range(0, 15);
      item.action = op;
      item.char_code = code;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_notices(item);
      if (op != ACTION_UNUSED) sent_count++;
   endtask

   task automatic drain_notices(int settle);
      req_valid <= 1'b0;
      while (pending_notices.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_colour(logic [15:0] value);
      drain_notices(SETTLE_CYCLES);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pen_colour = value;
   endtask

   task automatic test_directed_cases();
      send_request(ACTION_BACKSPACE, 8'h00);   // at origin
      send_request(ACTION_UNUSED, 8'hFF);
      send_request(ACTION_PUT, 8'h00);
      send_request(ACTION_PUT, 8'hFF);
      send_request(ACTION_PUT, 8'h55);
      send_request(ACTION_PUT, 8'hAA);
      send_request(ACTION_PUT, SPACE_CODE);    // blank over blank
      send_request(ACTION_BACKSPACE, 8'hFF);
      send_request(ACTION_BACKSPACE, 8'h00);
      send_request(ACTION_PUT, NEWLINE_CODE);
      send_request(ACTION_BACKSPACE, 8'h00);   // column 0 goes up a row
      send_request(ACTION_PUT, 8'h7E);         // last column, wraps
      send_request(ACTION_BACKSPACE, 8'h00);
      send_request(ACTION_PUT, 8'h7F);
      send_request(ACTION_PUT, NEWLINE_CODE);
      send_request(ACTION_CLEAR, 8'h00);
      send_request(ACTION_CLEAR, 8'hFF);       // already blank
      send_request(ACTION_PUT, 8'h41);
   endtask

   task automatic test_colour_register();
      logic [15:0] colours [4] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
      foreach (colours[i]) begin
         write_colour(colours[i]);
         send_request(ACTION_PUT, 8'($urandom_range(33, 126)));
         send_request(ACTION_BACKSPACE, 8'($urandom));
      end
   endtask

   task automatic test_screen_overflow();
      send_request(ACTION_CLEAR, 8'h00);
      repeat (ROWS) send_request(ACTION_PUT, NEWLINE_CODE);
      repeat (ROWS - 1) send_request(ACTION_PUT, NEWLINE_CODE);
      // last put lands in the bottom right cell
      repeat (COLUMNS) send_request(ACTION_PUT, 8'($urandom_range(33, 255)));
   endtask

   task automatic test_backpressure();
      drain_notices(SETTLE_CYCLES);
      quiet_sender = 1'b1;
      sink_hold_cycles = 400;
      repeat (30) send_request(ACTION_PUT, 8'($urandom_range(33, 126)));
      quiet_sender = 1'b0;
      drain_notices(0);
      repeat (20) send_request(action_type'($urandom_range(0, 1)), 8'($urandom));
   endtask

   task automatic test_random_traffic();
      int target;
      int choice;
      for (int phase = 0; phase < 4; phase++) begin
         write_colour(phase == 0 ? COLOR_RESET : 16'($urandom));
         quiet_sender = (phase == 2);
         quiet_sink   = (phase >= 2);
         target = sent_count + RANDOM_ITEMS / 4;
         while (sent_count < target) begin
            choice = $urandom_range(0, 99);
            if (choice < 50) begin
               repeat ($urandom_range(0, 20)) send_request(ACTION_PUT, 8'($urandom));
               send_request(ACTION_PUT, NEWLINE_CODE);
            end else if (choice < 60) begin
               repeat ($urandom_range(100, 160)) send_request(ACTION_PUT, 8'($urandom));
            end else if (choice < 70) begin
               repeat ($urandom_range(5, 40)) send_request(ACTION_PUT, NEWLINE_CODE);
            end else if (choice < 85) begin
               repeat ($urandom_range(1, 30)) send_request(ACTION_BACKSPACE, 8'($urandom));
            end else if (choice < 97) begin
               repeat ($urandom_range(1, 8))
                  send_request(action_type'($urandom_range(0, 3)), 8'($urandom));
            end else begin
               send_request(ACTION_CLEAR, 8'($urandom));
            end
         end
      end
      quiet_sender = 1'b0;
      quiet_sink   = 1'b0;
   endtask

   // result sink with random stalls and an optional long hold
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sink_wait = quiet_sink ? 0 : $urandom_range(0, 15);
         if (sink_hold_cycles > 0) begin
            sink_hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (sink_wait > 0) begin
            sink_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_notices.size() == 0) begin
            $error("notice with nothing expected: %p", rsp_data);
            mismatch_count++;
         end else begin
            expected_notice = pending_notices.pop_front();
            check_field("kind", expected_notice.kind, rsp_data.kind);
            check_field("cell_column", expected_notice.cell_column, rsp_data.cell_column);
            check_field("cell_row", expected_notice.cell_row, rsp_data.cell_row);
            check_field("pixel_x", expected_notice.pixel_x, rsp_data.pixel_x);
            check_field("pixel_y", expected_notice.pixel_y, rsp_data.pixel_y);
            check_field("glyph", expected_notice.glyph, rsp_data.glyph);
            check_field("colour", expected_notice.colour, rsp_data.colour);
            check_field("last", expected_notice.last, rsp_data.last);
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      mismatch_count   = 0;
      sent_count       = 0;
      sink_hold_cycles = 0;
      sink_wait        = 0;
      quiet_sender     = 1'b0;
      quiet_sink       = 1'b0;
      pen_colour       = COLOR_RESET;
      wipe_screen();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_colour_register();
      test_screen_overflow();
      test_backpressure();
      test_random_traffic();

      drain_notices(SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("PASS text_console_char_writer");
      end else begin
         $display("FAIL text_console_char_writer");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("FAIL text_console_char_writer");
      $finish;
   end

endmodule

// ----- text_console_char_writer.f -----
hdl/tccw_pkg.sv
hdl/text_console_char_writer.sv
tb/tb_text_console_char_writer.sv
